>>> sv/uule_pkg.sv
// uule_pkg: shared constants, command type and a character helper
// for the uuencode line encoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package uule_pkg;

  // bytes per full text line
  localparam int LINE_BYTES = 45;
  // store address, fill count and group index widths
  localparam int ADDR_W = $clog2(LINE_BYTES);
  localparam int CNT_W  = $clog2(LINE_BYTES + 1);
  localparam int GRP_W  = $clog2(LINE_BYTES + 3);

  // command queue depth (power of two)
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // request kinds on in_tuser
  localparam logic [1:0] REQ_DATA   = 2'd0;
  localparam logic [1:0] REQ_INIT   = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  // characters
  localparam logic [6:0] NL_CHAR   = 7'd10;
  localparam logic [6:0] SEQ_FIRST = 7'd122;  // 'z'
  localparam logic [6:0] SEQ_LAST  = 7'd97;   // 'a'
  localparam logic [6:0] ENC_BIAS  = 7'd32;   // ' '

  // front to back command: optional store write, optional line emit
  typedef struct packed {
    logic              wr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] waddr;
    logic              emit;
    logic [CNT_W-1:0]  n;
  } cmd_t;

  // six-bit value to printable character
  function automatic logic [6:0] enc6(input logic [5:0] v);
    return {1'b0, v} + ENC_BIAS;
  endfunction

endpackage
`default_nettype wire

>>> sv/uuencode_line_encoder.sv
// Flow: a data byte passes through the command queue and is written into the line store when
// the back end is idle; the closing beat's emit command passes through the queue and S_LEN.
// Throughput: beats enter at one per cycle while the two-entry command queue has room;
// the back end pops commands only when idle and sequences each line of n bytes group by group
// (3 byte reads then 4 characters per group).
// Reset: synchronous active-low rst_n clears fill count, queue and store valid bits; 'z'.
// Top level: front end, command queue and back end. Uses uule_pkg,
// uule_front, uule_cmdq and uule_back.
`timescale 1ns / 1ps
`default_nettype none
module uuencode_line_encoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output      logic       in_tready,
  input  wire logic [1:0] in_tuser,   // [1:0] req_type
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  output      logic       out_tvalid,
  input  wire logic       out_tready,
  output      logic [7:0] out_tdata,  // [6:0] out_char, [7] zero
  output      logic       out_tlast   // line_end
);

  logic           push;
  uule_pkg::cmd_t push_cmd;
  logic           q_full;
  logic           q_pop;
  uule_pkg::cmd_t q_cmd;
  logic           q_valid;

  uule_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tuser (in_tuser),
    .in_tdata (in_tdata),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  uule_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_cmd),
    .not_empty(q_valid)
  );

  uule_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule
`default_nettype wire

>>> sv/uule_ram.sv
// uule_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module uule_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 45
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

>>> sv/uule_front.sv
// uule_front: accepts request beats, keeps the fill count and turns
// data and finish requests into store write and/or line emit commands. Uses uule_pkg.
`timescale 1ns / 1ps
`default_nettype none
module uule_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output      logic                in_tready,
  input  wire logic [1:0]          in_tuser,  // [1:0] req_type
  input  wire logic [7:0]          in_tdata,  // [7:0] data_byte
  output      logic                push,
  output      uule_pkg::cmd_t      push_cmd,
  input  wire logic                q_full
);

  logic [uule_pkg::CNT_W-1:0]  fill_r, fill_nxt;
  logic [uule_pkg::ADDR_W-1:0] wr_addr;
  logic [uule_pkg::CNT_W-1:0]  fill_inc;
  logic                        accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // write slot and count after this byte
  assign wr_addr  = (fill_r >= uule_pkg::CNT_W'(uule_pkg::LINE_BYTES)) ?
                    '0 : fill_r[uule_pkg::ADDR_W-1:0];
  assign fill_inc = uule_pkg::CNT_W'(wr_addr) + 1'b1;

  // classify the request
  always_comb begin
    fill_nxt       = fill_r;
    push           = 1'b0;
    push_cmd       = '0;
    push_cmd.wdata = in_tdata;
    push_cmd.waddr = wr_addr;
    if (accept) begin
      unique case (in_tuser)
        uule_pkg::REQ_DATA: begin
          push        = 1'b1;
          push_cmd.wr = 1'b1;
          if (fill_inc == uule_pkg::CNT_W'(uule_pkg::LINE_BYTES)) begin
            push_cmd.emit = 1'b1;
            push_cmd.n    = fill_inc;
            fill_nxt      = '0;
          end else begin
            fill_nxt = fill_inc;
          end
        end
        uule_pkg::REQ_INIT: begin
          fill_nxt = '0;
        end
        default: begin
          // finish, and the unused code acting as finish
          if (fill_r != '0) begin
            push          = 1'b1;
            push_cmd.emit = 1'b1;
            push_cmd.n    = fill_r;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // checks
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full) else $error("command pushed into full queue");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < uule_pkg::CNT_W'(uule_pkg::LINE_BYTES))
    else $error("fill count reached line length");
  a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_cmd.emit |-> push_cmd.n != '0)
    else $error("emit command for empty line");

endmodule
`default_nettype wire

>>> sv/uule_cmdq.sv
// uule_cmdq: short command queue between front and back.
// Uses uule_pkg.
`timescale 1ns / 1ps
`default_nettype none
module uule_cmdq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire uule_pkg::cmd_t push_cmd,
  output      logic           full,
  input  wire logic           pop,
  output      uule_pkg::cmd_t pop_cmd,
  output      logic           not_empty
);

  uule_pkg::cmd_t               ent_r [uule_pkg::Q_DEPTH];
  logic [uule_pkg::Q_PTR_W-1:0] wr_ptr_r;
  logic [uule_pkg::Q_PTR_W-1:0] rd_ptr_r;
  logic [uule_pkg::Q_CNT_W-1:0] cnt_r;
  logic                         do_push;
  logic                         do_pop;

  assign full      = (cnt_r == uule_pkg::Q_CNT_W'(uule_pkg::Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_cmd   = ent_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

>>> sv/uule_back.sv
// uule_back: executes store writes and sequences the text line out of
// the line store, one character per beat. Uses uule_pkg and uule_ram.
`timescale 1ns / 1ps
`default_nettype none
module uule_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire uule_pkg::cmd_t q_cmd,
  output      logic           q_pop,
  output      logic           out_tvalid,
  input  wire logic           out_tready,
  output      logic [7:0]     out_tdata,  // [6:0] out_char, [7] zero
  output      logic           out_tlast   // line_end
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LEN  = 4'd1;
  localparam logic [3:0] S_RD0  = 4'd2;
  localparam logic [3:0] S_RD1  = 4'd3;
  localparam logic [3:0] S_RD2  = 4'd4;
  localparam logic [3:0] S_RD3  = 4'd5;
  localparam logic [3:0] S_C0   = 4'd6;
  localparam logic [3:0] S_C1   = 4'd7;
  localparam logic [3:0] S_C2   = 4'd8;
  localparam logic [3:0] S_C3   = 4'd9;
  localparam logic [3:0] S_SEQ  = 4'd10;
  localparam logic [3:0] S_NL   = 4'd11;

  logic [3:0]                     state_r, state_nxt;
  logic [uule_pkg::CNT_W-1:0]     n_r, n_nxt;
  logic [uule_pkg::GRP_W-1:0]     grp_r, grp_nxt;
  logic [6:0]                     seq_r, seq_nxt;
  logic [uule_pkg::LINE_BYTES-1:0] vld_r, vld_nxt;
  logic [7:0]                     b0_r, b0_nxt, b1_r, b1_nxt, b2_r, b2_nxt;
  logic                           rd_ok_r, rd_ok_nxt;
  logic                           ovld_r, ovld_nxt;
  logic [6:0]                     ochar_r, ochar_nxt;
  logic                           olast_r, olast_nxt;

  logic                           can_out;
  logic                           ram_we;
  logic [uule_pkg::GRP_W-1:0]     rd_pos;
  logic [uule_pkg::ADDR_W-1:0]    ram_raddr;
  logic [7:0]                     ram_rdata;
  logic [7:0]                     rd_byte;
  logic                           rd_in_rng;

  assign can_out    = !ovld_r || out_tready;
  assign out_tvalid = ovld_r;
  assign out_tdata  = {1'b0, ochar_r};
  assign out_tlast  = olast_r;

  // store read: positions past the store, or never written, read as zero
  assign rd_in_rng = (rd_pos < uule_pkg::GRP_W'(uule_pkg::LINE_BYTES));
  assign ram_raddr = rd_in_rng ? rd_pos[uule_pkg::ADDR_W-1:0] : '0;
  assign rd_byte   = rd_ok_r ? ram_rdata : 8'h00;
  assign ram_we    = q_pop && q_cmd.wr;

  uule_ram #(
    .WIDTH(8),
    .DEPTH(uule_pkg::LINE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(q_cmd.waddr),
    .wdata(q_cmd.wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // line sequencer
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    grp_nxt   = grp_r;
    seq_nxt   = seq_r;
    vld_nxt   = vld_r;
    b0_nxt    = b0_r;
    b1_nxt    = b1_r;
    b2_nxt    = b2_r;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    ovld_nxt  = ovld_r && !out_tready;
    q_pop     = 1'b0;
    rd_pos    = grp_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.wr) begin
            vld_nxt[q_cmd.waddr] = 1'b1;
          end
          if (q_cmd.emit) begin
            n_nxt     = q_cmd.n;
            grp_nxt   = '0;
            state_nxt = S_LEN;
          end
        end
      end
      S_LEN: begin
        if (can_out) begin
          ovld_nxt  = 1'b1;
          ochar_nxt = uule_pkg::enc6(6'(n_r));
          olast_nxt = 1'b0;
          state_nxt = S_RD0;
        end
      end
      S_RD0: begin
        rd_pos    = grp_r;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        rd_pos    = grp_r + 1'b1;
        b0_nxt    = rd_byte;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        rd_pos    = grp_r + 2'd2;
        b1_nxt    = rd_byte;
        state_nxt = S_RD3;
      end
      S_RD3: begin
        b2_nxt    = rd_byte;
        state_nxt = S_C0;
      end
      S_C0: begin
        if (can_out) begin
          ovld_nxt  = 1'b1;
          ochar_nxt = uule_pkg::enc6(b0_r[7:2]);
          olast_nxt = 1'b0;
          state_nxt = S_C1;
        end
      end
      S_C1: begin
        if (can_out) begin
          ovld_nxt  = 1'b1;
          ochar_nxt = uule_pkg::enc6({b0_r[1:0], b1_r[7:4]});
          olast_nxt = 1'b0;
          state_nxt = S_C2;
        end
      end
      S_C2: begin
        if (can_out) begin
          ovld_nxt  = 1'b1;
          ochar_nxt = uule_pkg::enc6({b1_r[3:0], b2_r[7:6]});
          olast_nxt = 1'b0;
          state_nxt = S_C3;
        end
      end
      S_C3: begin
        if (can_out) begin
          ovld_nxt  = 1'b1;
          ochar_nxt = uule_pkg::enc6(b2_r[5:0]);
          olast_nxt = 1'b0;
          grp_nxt   = grp_r + 2'd3;
          state_nxt = ((grp_r + 2'd3) >= uule_pkg::GRP_W'(n_r)) ? S_SEQ : S_RD0;
        end
      end
      S_SEQ: begin
        if (can_out) begin
          ovld_nxt  = 1'b1;
          ochar_nxt = seq_r;
          olast_nxt = 1'b0;
          state_nxt = S_NL;
        end
      end
      S_NL: begin
        if (can_out) begin
          ovld_nxt  = 1'b1;
          ochar_nxt = uule_pkg::NL_CHAR;
          olast_nxt = 1'b1;
          seq_nxt   = (seq_r <= uule_pkg::SEQ_LAST) ? uule_pkg::SEQ_FIRST :
                      seq_r - 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    rd_ok_nxt = rd_in_rng && vld_r[ram_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seq_r   <= uule_pkg::SEQ_FIRST;
      vld_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seq_r   <= seq_nxt;
      vld_r   <= vld_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    grp_r   <= grp_nxt;
    b0_r    <= b0_nxt;
    b1_r    <= b1_nxt;
    b2_r    <= b2_nxt;
    rd_ok_r <= rd_ok_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  // checks
  a_last_is_nl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[6:0] == uule_pkg::NL_CHAR)
    else $error("line end on a character other than newline");
  a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r >= uule_pkg::SEQ_LAST && seq_r <= uule_pkg::SEQ_FIRST)
    else $error("sequence letter out of range");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE && q_valid)
    else $error("command popped while busy");
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_NL && can_out |=> seq_r != $past(seq_r))
    else $error("sequence letter not advanced after line");

endmodule
`default_nettype wire
